// ===== rtl/cbz_pkg.sv =====
`timescale 1ns / 1ps

package cbz_pkg;

  // Field widths.
  localparam int T_W     = 17;
  localparam int COORD_W = 16;

  // Q0.16 value of 1.0.
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // Coordinates scaled by the binomial factor three need two more bits.
  localparam int SC_W = COORD_W + 2;

  // Squares of t or u, and the cubic weights (Q0.32 and Q0.48, 1.0 included).
  localparam int SQ_W = 2 * T_W - 1;
  localparam int W_W  = 3 * (T_W - 1) + 1;

  // Weights are split in a low and a high part for the coordinate multiply.
  localparam int LO_W  = 25;
  localparam int HI_W  = W_W - LO_W;
  localparam int LOP_W = LO_W + SC_W;
  localparam int HIP_W = HI_W + SC_W;
  localparam int LOS_W = LOP_W + 2;
  localparam int HIS_W = HIP_W + 2;

  // The full weighted sum and its fraction.
  localparam int SUM_W      = 64;
  localparam int FRAC_SHIFT = 48;

  // Pipeline stages.
  localparam int STG_SCALE = 0;
  localparam int STG_SQ    = 1;
  localparam int STG_WGT   = 2;
  localparam int STG_MUL   = 3;
  localparam int STG_PAIR  = 4;
  localparam int STG_SUM   = 5;
  localparam int STG_ADD   = 6;
  localparam int STG_CLAMP = 7;
  localparam int NSTAGE    = 8;

  // Configuration registers.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COORD_W;

  typedef logic [T_W-1:0]       tpar_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [W_W-1:0]       wgt_t;
  typedef logic [NSTAGE-1:0]    stage_vec_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_X_LIMIT = 1'd0;
  localparam cfg_idx_t REG_Y_LIMIT = 1'd1;

  localparam coord_t X_LIMIT_RST = 16'd20416;
  localparam coord_t Y_LIMIT_RST = 16'd15296;

endpackage

// ===== rtl/cbz_req_if.sv =====
`timescale 1ns / 1ps

interface cbz_req_if import cbz_pkg::*; ();
  logic   valid;
  logic   ready;
  tpar_t  t_param;
  coord_t p0_x;
  coord_t p0_y;
  coord_t p1_x;
  coord_t p1_y;
  coord_t p2_x;
  coord_t p2_y;
  coord_t p3_x;
  coord_t p3_y;

  modport source (
    output valid, t_param, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );

  modport sink (
    input  valid, t_param, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

// ===== rtl/cbz_rsp_if.sv =====
`timescale 1ns / 1ps

interface cbz_rsp_if import cbz_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;

  modport source (
    output valid, out_x, out_y,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y,
    output ready
  );
endinterface

// ===== rtl/cbz_weights.sv =====
`timescale 1ns / 1ps

module cbz_weights import cbz_pkg::*; (
  input  logic       clk,
  input  stage_vec_t adv,
  input  tpar_t      t_param,
  output wgt_t       wgt [4]
);

  tpar_t               t_sat;
  tpar_t               t0, u0, t1, u1;
  logic [SQ_W-1:0]     tt, uu;

  // Anything above 1.0 is taken as 1.0.
  assign t_sat = (t_param > T_ONE) ? T_ONE : t_param;

  always_ff @(posedge clk) begin
    if (adv[STG_SCALE]) begin
      t0 <= t_sat;
      u0 <= T_ONE - t_sat;
    end
    if (adv[STG_SQ]) begin
      tt <= SQ_W'(t0) * SQ_W'(t0);
      uu <= SQ_W'(u0) * SQ_W'(u0);
      t1 <= t0;
      u1 <= u0;
    end
    // Weights without the binomial factor; the factor three is applied to
    // the inner control points instead.
    if (adv[STG_WGT]) begin
      wgt[0] <= W_W'(uu) * W_W'(u1);
      wgt[1] <= W_W'(uu) * W_W'(t1);
      wgt[2] <= W_W'(tt) * W_W'(u1);
      wgt[3] <= W_W'(tt) * W_W'(t1);
    end
  end

endmodule

// ===== rtl/cbz_blend.sv =====
`timescale 1ns / 1ps

module cbz_blend import cbz_pkg::*; (
  input  logic       clk,
  input  stage_vec_t adv,
  input  coord_t     p0,
  input  coord_t     p1,
  input  coord_t     p2,
  input  coord_t     p3,
  input  wgt_t       wgt [4],
  input  coord_t     limit,
  output coord_t     res
);

  logic [SC_W-1:0]  c0 [4];
  logic [SC_W-1:0]  c1 [4];
  logic [SC_W-1:0]  c2 [4];
  logic [LOP_W-1:0] lo [4];
  logic [HIP_W-1:0] hi [4];
  logic [LOS_W-1:0] lo01, lo23, lo_sum;
  logic [HIS_W-1:0] hi01, hi23, hi_sum;
  logic [SUM_W-1:0] total;
  coord_t           raw;

  assign total = (SUM_W'(hi_sum) << LO_W) + SUM_W'(lo_sum);

  always_ff @(posedge clk) begin
    if (adv[STG_SCALE]) begin
      c0[0] <= SC_W'(p0);
      c0[1] <= SC_W'(p1) + (SC_W'(p1) << 1);
      c0[2] <= SC_W'(p2) + (SC_W'(p2) << 1);
      c0[3] <= SC_W'(p3);
    end
    if (adv[STG_SQ]) begin
      c1 <= c0;
    end
    if (adv[STG_WGT]) begin
      c2 <= c1;
    end
    if (adv[STG_MUL]) begin
      for (int i = 0; i < 4; i++) begin
        lo[i] <= LOP_W'(wgt[i][LO_W-1:0]) * LOP_W'(c2[i]);
        hi[i] <= HIP_W'(wgt[i][W_W-1:LO_W]) * HIP_W'(c2[i]);
      end
    end
    if (adv[STG_PAIR]) begin
      lo01 <= LOS_W'(lo[0]) + LOS_W'(lo[1]);
      lo23 <= LOS_W'(lo[2]) + LOS_W'(lo[3]);
      hi01 <= HIS_W'(hi[0]) + HIS_W'(hi[1]);
      hi23 <= HIS_W'(hi[2]) + HIS_W'(hi[3]);
    end
    if (adv[STG_SUM]) begin
      lo_sum <= lo01 + lo23;
      hi_sum <= hi01 + hi23;
    end
    // The weights add up to 1.0 in Q0.48, so the top bits are the point.
    if (adv[STG_ADD]) begin
      raw <= total[SUM_W-1:FRAC_SHIFT];
    end
    if (adv[STG_CLAMP]) begin
      res <= (raw > limit) ? limit : raw;
    end
  end

endmodule

// ===== rtl/cubic_bezier_point_evaluator.sv =====
`timescale 1ns / 1ps

// Cubic Bezier point evaluator. Each request carries a curve parameter t
// (unsigned Q0.16, where 65536 is 1.0 and anything larger counts as 1.0) and
// four control points in unsigned Q10.6. The response is the exact point
// u^3*P0 + 3u^2t*P1 + 3ut^2*P2 + t^3*P3 with u = 1 - t, truncated to Q10.6
// and then limited from above by x_limit and y_limit. The block takes one
// request per clock while the response side does not stall and returns one
// response per request, in order. The work is split over an eight-stage
// pipeline: t clamp and coordinate scaling, squares, cubic weights, split
// weight times coordinate products, two adder levels, the final 64-bit add,
// and the clamp in the output register. Each stage carries a valid bit and
// refills as soon as its item moves on, so bubbles close up behind a stalled
// response. The limits should be written only while no request is in flight.

module cubic_bezier_point_evaluator import cbz_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cbz_req_if.sink         req,
  cbz_rsp_if.source       rsp
);

  coord_t          x_limit;
  coord_t          y_limit;
  stage_vec_t      v;
  stage_vec_t      adv;
  logic [NSTAGE:0] rdy;
  wgt_t            wgt [4];
  coord_t          res_x;
  coord_t          res_y;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= X_LIMIT_RST;
      y_limit <= Y_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_LIMIT: x_limit <= cfg_wdata;
        REG_Y_LIMIT: y_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its item leaves this cycle.
  always_comb begin
    rdy[NSTAGE] = rsp.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
    adv = rdy[NSTAGE-1:0];
  end

  assign req.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= req.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  cbz_weights u_weights (
    .clk     (clk),
    .adv     (adv),
    .t_param (req.t_param),
    .wgt     (wgt)
  );

  cbz_blend u_blend_x (
    .clk   (clk),
    .adv   (adv),
    .p0    (req.p0_x),
    .p1    (req.p1_x),
    .p2    (req.p2_x),
    .p3    (req.p3_x),
    .wgt   (wgt),
    .limit (x_limit),
    .res   (res_x)
  );

  cbz_blend u_blend_y (
    .clk   (clk),
    .adv   (adv),
    .p0    (req.p0_y),
    .p1    (req.p1_y),
    .p2    (req.p2_y),
    .p3    (req.p3_y),
    .wgt   (wgt),
    .limit (y_limit),
    .res   (res_y)
  );

  assign rsp.valid = v[STG_CLAMP];
  assign rsp.out_x = res_x;
  assign rsp.out_y = res_y;

  // An accepted request always lands in the first stage.
  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v[STG_SCALE])
    else $error("accepted request did not enter the pipeline");

  // A full pipeline facing a stalled response must not take a new request.
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (&v) && !rsp.ready |-> !req.ready)
    else $error("request accepted while the pipeline was full and stalled");

  // A held response stays valid until it is taken.
  a_hold_out : assert property (@(posedge clk) disable iff (rst)
    v[STG_CLAMP] && !rsp.ready |=> v[STG_CLAMP])
    else $error("stalled response was dropped");

  // An item in the middle of the pipeline is never lost while blocked.
  a_hold_mid : assert property (@(posedge clk) disable iff (rst)
    v[STG_MUL] && !rdy[STG_PAIR] |=> v[STG_MUL])
    else $error("blocked pipeline item was dropped");

endmodule
